FILE: hw/rtl/tiny_stack_isa_execute_unit_defines.svh
// Assertion macros shared by the execute unit RTL.
`ifndef TINY_STACK_ISA_EXECUTE_UNIT_DEFINES_SVH
`define TINY_STACK_ISA_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define TSIE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define TSIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/tsie_pkg.sv
package tsie_pkg;

   localparam int MEMORY_WORDS_DEFAULT = 1024;
   localparam int REG_COUNT = 6;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 184;
   localparam logic [2:0] REG_ESP = 3'd3;
   localparam logic [2:0] REG_EBP = 3'd4;
   localparam logic [2:0] REG_EIP = 3'd5;

   typedef enum logic [3:0] {
      OP_MOVL = 4'd0, OP_ADDL = 4'd1, OP_PUSH = 4'd2, OP_POP = 4'd3,
      OP_CMP = 4'd4, OP_CALL = 4'd5, OP_RET = 4'd6, OP_JMP = 4'd7,
      OP_JE = 4'd8, OP_JNE = 4'd9, OP_JL = 4'd10, OP_JG = 4'd11,
      OP_NOP = 4'd12, OP_END = 4'd13
   } op_type;

   typedef enum logic [1:0] {
      KIND_UNKNOWN = 2'd0, KIND_REG = 2'd1, KIND_MEM = 2'd2, KIND_CONST = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_INSTR_ERR = 3'd1, ST_MEM_ERR = 3'd2,
      ST_PC_ERR = 3'd3, ST_HALT = 3'd4
   } status_type;

   // Request payload, lowest field in the lowest bits
   typedef struct packed {
      logic [12:0] target_address;
      logic        target_found;
      logic [31:0] dst_value;
      logic [2:0]  dst_reg;
      logic [1:0]  dst_kind;
      logic [31:0] src_value;
      logic [2:0]  src_reg;
      logic [1:0]  src_kind;
      logic [3:0]  operation;
   } req_type;

   typedef struct packed {
      logic [31:0] compare_value;
      logic [31:0] stack_pointer;
      logic [31:0] mem_value;
      logic [9:0]  mem_index;
      logic        mem_written;
      logic [31:0] reg_value;
      logic [2:0]  reg_index;
      logic        reg_written;
      logic [31:0] next_pc;
      logic [2:0]  status;
   } rsp_type;

   typedef logic [REG_COUNT-1:0][31:0] rf_type;

   // Register/memory operand naming a missing register is unknown
   function automatic logic [1:0] norm_kind(logic [1:0] kind, logic [2:0] r);
      if ((kind == KIND_REG || kind == KIND_MEM) && r > 3'd5) return KIND_UNKNOWN;
      return kind;
   endfunction

   function automatic logic [31:0] rf_read(rf_type rf, logic [2:0] r);
      logic [31:0] v;
      v = '0;
      for (int i = 0; i < REG_COUNT; i++) begin
         if (r == 3'(i)) v = rf[i];
      end
      return v;
   endfunction

   // Byte address of the single data word an instruction may read
   function automatic logic [31:0] read_addr(req_type q, rf_type rf);
      logic [1:0] sk;
      logic [31:0] a;
      sk = norm_kind(q.src_kind, q.src_reg);
      a = rf_read(rf, q.src_reg) + q.src_value;
      case (q.operation)
         OP_ADDL: if (norm_kind(q.dst_kind, q.dst_reg) == KIND_MEM)
            a = rf_read(rf, q.dst_reg) + q.dst_value;
         OP_CMP: if (sk != KIND_MEM) a = rf_read(rf, q.dst_reg) + q.dst_value;
         OP_POP, OP_RET: a = rf[REG_ESP];
         default: a = rf_read(rf, q.src_reg) + q.src_value;
      endcase
      return a;
   endfunction

endpackage

FILE: hw/rtl/tsie_ram.sv
module tsie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

FILE: hw/rtl/tsie_exec.sv
// Combinational execute: one instruction against the register file and the
// word read from data memory.
module tsie_exec #(
   parameter int MEMORY_WORDS = tsie_pkg::MEMORY_WORDS_DEFAULT
) (
   input  tsie_pkg::req_type              item,
   input  tsie_pkg::rf_type               rf,
   input  logic [31:0]                    cmp,
   input  logic [10:0]                    prog_len,
   input  logic [31:0]                    rdata,
   output tsie_pkg::rf_type               rf_next,
   output logic [31:0]                    cmp_next,
   output logic                           mem_we,
   output logic [$clog2(MEMORY_WORDS)-1:0] mem_widx,
   output tsie_pkg::rsp_type              result
);
   import tsie_pkg::*;

   localparam int AW = $clog2(MEMORY_WORDS);
   localparam logic [31:0] ADDR_MAX = 32'((MEMORY_WORDS - 1) * 4);
   localparam logic [31:0] WORD_MAX = 32'(MEMORY_WORDS - 1);

   function automatic logic ok(logic [31:0] a);
      return a <= ADDR_MAX;
   endfunction

   always_comb begin
      logic [1:0]  sk, dk;
      logic [31:0] sreg, dreg, asrc, adst, esp, eip, sp, v, v2, ta, c;
      logic        adv, take, st_set;
      logic [2:0]  st;
      sk = norm_kind(item.src_kind, item.src_reg);
      dk = norm_kind(item.dst_kind, item.dst_reg);
      sreg = rf_read(rf, item.src_reg);
      dreg = rf_read(rf, item.dst_reg);
      asrc = sreg + item.src_value;
      adst = dreg + item.dst_value;
      esp = rf[REG_ESP];
      eip = rf[REG_EIP];
      ta = {19'd0, item.target_address};
      c = cmp;
      sp = '0; v = '0; v2 = '0; take = 1'b0; st_set = 1'b0;
      adv = 1'b0;
      st = ST_OK;
      rf_next = rf;
      cmp_next = cmp;
      mem_we = 1'b0;
      mem_widx = '0;
      result = '0;

      // local helpers inline: register write and memory write
      case (item.operation)
         OP_MOVL: begin
            adv = 1'b1;
            if (sk == KIND_REG || sk == KIND_CONST) begin
               v = (sk == KIND_REG) ? sreg : item.src_value;
               if (dk == KIND_REG) begin
                  result.reg_written = 1'b1;
                  result.reg_value = v;
               end else if (dk == KIND_MEM) begin
                  if (!ok(adst)) st = ST_MEM_ERR;
                  else begin
                     mem_we = 1'b1; mem_widx = adst[AW+1:2]; result.mem_value = v;
                  end
               end else st = ST_INSTR_ERR;
            end else if (sk == KIND_MEM && dk == KIND_REG) begin
               if (!ok(asrc)) st = ST_MEM_ERR;
               else begin
                  result.reg_written = 1'b1; result.reg_value = rdata;
               end
            end else st = ST_INSTR_ERR;
         end
         OP_ADDL: begin
            adv = 1'b1;
            if (dk == KIND_REG) begin
               if (sk == KIND_CONST) begin
                  result.reg_written = 1'b1; result.reg_value = dreg + item.src_value;
               end else if (sk == KIND_MEM) begin
                  if (!ok(asrc)) st = ST_MEM_ERR;
                  else begin
                     result.reg_written = 1'b1; result.reg_value = dreg + rdata;
                  end
               end else if (sk == KIND_REG) begin
                  result.reg_written = 1'b1; result.reg_value = dreg + sreg;
               end else st = ST_INSTR_ERR;
            end else if (dk == KIND_MEM) begin
               if (!ok(adst)) st = ST_MEM_ERR;
               else if (sk == KIND_CONST || sk == KIND_REG) begin
                  mem_we = 1'b1; mem_widx = adst[AW+1:2];
                  result.mem_value = rdata + ((sk == KIND_REG) ? sreg : item.src_value);
               end else st = ST_INSTR_ERR;
            end else st = ST_INSTR_ERR;
         end
         OP_PUSH: begin
            adv = 1'b1;
            sp = esp - 32'd4;
            if (!ok(sp)) st = ST_MEM_ERR;
            else if (sk == KIND_UNKNOWN) st = ST_INSTR_ERR;
            else if (sk == KIND_MEM) begin
               if (!ok(asrc)) st = ST_MEM_ERR;
               else v = rdata;
            end else v = (sk == KIND_REG) ? sreg : item.src_value;
            if (st == ST_OK) begin
               rf_next[REG_ESP] = sp;
               mem_we = 1'b1; mem_widx = sp[AW+1:2]; result.mem_value = v;
            end
         end
         OP_POP: begin
            adv = 1'b1;
            if (!ok(esp) || !ok(esp + 32'd4)) st = ST_MEM_ERR;
            else if (dk == KIND_MEM) begin
               if (!ok(adst)) st = ST_MEM_ERR;
               else begin
                  mem_we = 1'b1; mem_widx = adst[AW+1:2]; result.mem_value = rdata;
                  rf_next[REG_ESP] = esp + 32'd4;
               end
            end else if (dk == KIND_REG) begin
               result.reg_written = 1'b1; result.reg_value = rdata;
               st_set = 1'b1;
            end else st = ST_INSTR_ERR;
         end
         OP_CMP: begin
            adv = 1'b1;
            if (sk == KIND_UNKNOWN) st = ST_INSTR_ERR;
            else if (sk == KIND_MEM) begin
               if (dk == KIND_MEM) st = ST_INSTR_ERR;
               else if (!ok(asrc)) st = ST_MEM_ERR;
               else v = rdata;
            end else v = (sk == KIND_REG) ? sreg : item.src_value;
            if (st == ST_OK) begin
               if (dk == KIND_UNKNOWN) st = ST_INSTR_ERR;
               else if (dk == KIND_MEM) begin
                  if (!ok(adst)) st = ST_MEM_ERR;
                  else v2 = rdata;
               end else v2 = (dk == KIND_REG) ? dreg : item.dst_value;
            end
            if (st == ST_OK) cmp_next = v2 - v;
         end
         OP_CALL: begin
            if (!item.target_found || !ok(ta)) st = ST_PC_ERR;
            else begin
               sp = esp - 32'd4;
               if (ok(sp)) begin
                  rf_next[REG_ESP] = sp;
                  mem_we = 1'b1; mem_widx = sp[AW+1:2]; result.mem_value = eip + 32'd4;
               end
               rf_next[REG_EIP] = ta;
            end
         end
         OP_RET: begin
            v = eip;
            if (ok(esp) && ok(esp + 32'd4)) begin
               v = rdata;
               rf_next[REG_ESP] = esp + 32'd4;
            end
            rf_next[REG_EIP] = v;
            if (v[31] || (v >> 2) > {21'd0, prog_len} || (v >> 2) > WORD_MAX)
               st = ST_PC_ERR;
         end
         OP_JMP, OP_JE, OP_JNE, OP_JL, OP_JG: begin
            if (!item.target_found || !ok(ta)) st = ST_PC_ERR;
            else begin
               case (item.operation)
                  OP_JMP:  take = 1'b1;
                  OP_JE:   take = (c == '0);
                  OP_JNE:  take = (c != '0);
                  OP_JL:   take = c[31];
                  default: take = (c != '0) && !c[31];
               endcase
               rf_next[REG_EIP] = take ? ta : eip + 32'd4;
            end
         end
         OP_END: st = ST_HALT;
         default: adv = 1'b1;
      endcase

      // destination register write, then pop and pc adjustments on top
      if (result.reg_written) begin
         result.reg_index = item.dst_reg;
         for (int i = 0; i < REG_COUNT; i++) begin
            if (item.dst_reg == 3'(i)) rf_next[i] = result.reg_value;
         end
      end
      if (st_set) rf_next[REG_ESP] = rf_next[REG_ESP] + 32'd4;
      if (adv) rf_next[REG_EIP] = rf_next[REG_EIP] + 32'd4;

      result.mem_written = mem_we;
      result.mem_index = 10'(mem_widx);
      result.status = st;
      result.next_pc = rf_next[REG_EIP];
      result.stack_pointer = rf_next[REG_ESP];
      result.compare_value = cmp_next;
   end
endmodule

FILE: hw/rtl/tiny_stack_isa_execute_unit.sv
// Channel  | Dir | Handshake             | Payload
// req      | in  | req_tvalid/req_tready | req_tdata: one decoded instruction
// rsp      | out | rsp_tvalid/rsp_tready | rsp_tdata: status, pc, writes, sp, cmp
// csr      | in  | csr_we                | csr_wdata: program_length
//
// Each request passes through a data memory read cycle, then an execute/write
// cycle; the registered-read data RAM, read then written, sets this. A new request
// is taken in the execute cycle of the previous one, once that one completes.
// After reset a clearing pass zeroes every data memory word, with req_tready
// low. A stalled response holds the execute stage.
module tiny_stack_isa_execute_unit #(
   parameter int MEMORY_WORDS = tsie_pkg::MEMORY_WORDS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // operation, src_kind, src_reg, src_value, dst_kind, dst_reg, dst_value,
   // target_found, target_address, zero pad
   input  logic [tsie_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status, next_pc, reg_written, reg_index, reg_value, mem_written,
   // mem_index, mem_value, stack_pointer, compare_value, zero pad
   output logic [tsie_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [10:0]                       csr_wdata
);
   import tsie_pkg::*;
   `include "tiny_stack_isa_execute_unit_defines.svh"

   localparam int AW = $clog2(MEMORY_WORDS);
   localparam logic [31:0] SP_RESET = 32'(MEMORY_WORDS - 256);

   req_type        item_ff, item_in;
   rf_type         rf_ff, rf_in;
   logic [31:0]    cmp_ff, cmp_in;
   logic [10:0]    len_ff;
   logic           rd_vld_ff, ex_vld_ff, out_vld_ff, clr_ff;
   logic [AW-1:0]  clr_cnt_ff;
   rsp_type        res_ff, res;
   logic           ex_done, accept, ex_mem_we, ram_we;
   logic [AW-1:0]  ex_widx, ram_waddr;
   logic [31:0]    rd_addr, ram_rdata, ram_wdata;

   // handshake
   assign ex_done = ex_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !clr_ff && !rd_vld_ff && (!ex_vld_ff || ex_done);
   assign accept = req_tvalid && req_tready;
   assign item_in = accept ? req_type'(req_tdata[$bits(req_type)-1:0]) : item_ff;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = {(RSP_DATA_W - $bits(rsp_type))'(0), res_ff};

   // memory read address from the staged request
   assign rd_addr = read_addr(item_ff, rf_ff);

   tsie_exec #(.MEMORY_WORDS(MEMORY_WORDS)) u_exec (
      .item     (item_ff),
      .rf       (rf_ff),
      .cmp      (cmp_ff),
      .prog_len (len_ff),
      .rdata    (ram_rdata),
      .rf_next  (rf_in),
      .cmp_next (cmp_in),
      .mem_we   (ex_mem_we),
      .mem_widx (ex_widx),
      .result   (res)
   );

   // data memory, zeroed by the clearing pass
   assign ram_we = clr_ff || (ex_done && ex_mem_we);
   assign ram_waddr = clr_ff ? clr_cnt_ff : ex_widx;
   assign ram_wdata = clr_ff ? '0 : res.mem_value;

   tsie_ram #(.WIDTH(32), .DEPTH(MEMORY_WORDS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (rd_addr[AW+1:2]),
      .rdata (ram_rdata)
   );

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         ex_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         clr_ff <= 1'b1;
         clr_cnt_ff <= '0;
         len_ff <= '0;
         cmp_ff <= '0;
         rf_ff <= '0;
         rf_ff[REG_ESP] <= SP_RESET;
         rf_ff[REG_EBP] <= SP_RESET;
      end else begin
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(MEMORY_WORDS - 1)) clr_ff <= 1'b0;
         end
         if (csr_we) len_ff <= csr_wdata;
         rd_vld_ff <= accept;
         if (rd_vld_ff) ex_vld_ff <= 1'b1;
         else if (ex_done) ex_vld_ff <= 1'b0;
         if (ex_done) begin
            out_vld_ff <= 1'b1;
            rf_ff <= rf_in;
            cmp_ff <= cmp_in;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (ex_done) res_ff <= res;
   end

   `TSIE_ASSERT_NOW(a_no_req_in_clear, clock, reset, clr_ff, !req_tready, "request taken during clear")
   `TSIE_ASSERT_NOW(a_ram_write_src, clock, reset, ram_we, clr_ff || ex_done, "stray memory write")
   `TSIE_ASSERT_NEXT(a_exec_to_rsp, clock, reset, ex_done, rsp_tvalid, "execute did not post response")
   `TSIE_ASSERT_NOW(a_one_stage, clock, reset, rd_vld_ff, !ex_vld_ff, "two requests in flight")
endmodule
